// File: rtl/lidar_polar_to_cartesian_core_assert.svh
// Assertion helpers for the lidar polar-to-cartesian core.
`ifndef LIDAR_POLAR_TO_CARTESIAN_CORE_ASSERT_SVH
`define LIDAR_POLAR_TO_CARTESIAN_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LP2C_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LP2C_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lp2c_pkg.sv
package lp2c_pkg;

    // Q1.30 fixed point for angles in radians and for sin/cos.
    localparam int QF       = 30;
    localparam int QW       = 31;    // holds 0 .. just under 2.0
    localparam int XW       = 32;    // theta^2 and Horner products
    localparam int DIV_W    = 9;
    localparam int HORNER_N = 8;

    localparam logic [QW-1:0] Q_ONE       = 31'h4000_0000;
    localparam logic [QW-1:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [XW:0]   RECIP_NUM   = 33'h1_0000_0000;

    localparam logic [DIV_W-1:0] SIN_DIV [HORNER_N] = '{
        9'd272, 9'd210, 9'd156, 9'd110, 9'd72, 9'd42, 9'd20, 9'd6
    };
    localparam logic [DIV_W-1:0] COS_DIV [HORNER_N] = '{
        9'd240, 9'd182, 9'd132, 9'd90, 9'd56, 9'd30, 9'd12, 9'd2
    };

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 1'b1;

    // Quadrant codes (top two angle bits).
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Finish one Horner step: fix the reciprocal quotient estimate e of v / k
    // (low by at most one), then t = 1 - q clamped to [0, 1].
    function automatic logic [QW-1:0] lp2c_horner_fix(
        input logic [XW-1:0]    v,
        input logic [XW-1:0]    e,
        input logic [DIV_W-1:0] k
    );
        logic [XW+DIV_W-1:0] ek_full;
        logic [XW-1:0]       rem;
        logic [XW-1:0]       q;
        ek_full = e * k;
        rem     = v - ek_full[XW-1:0];
        q       = (rem >= XW'(k)) ? e + XW'(1) : e;
        if (q > XW'(Q_ONE)) begin
            return '0;
        end
        return Q_ONE - q[QW-1:0];
    endfunction

endpackage

// File: rtl/lidar_polar_to_cartesian_core.sv
// Lidar polar-to-cartesian core.
// Input channel: i_in_valid / o_in_stall carries one beam (range, range valid,
// start-of-scan). Each accepted beam takes angle_start if start-of-scan is
// set, else the running angle, and leaves angle + angle_step as the next one.
// Output channel: o_out_valid / i_out_stall carries one point (x, y, angle)
// per beam with a valid range; beams without a return give no point.
// Config: i_cfg_wen writes register i_cfg_idx (0 angle_start, 1 angle_step);
// write only while the core is empty.
// Throughput: one beam per clock while the output is not stalled. Stages,
// from beam transfer to presented point:
// entry, theta, theta^2, 8 Horner steps of 3 stages each (multiply,
// reciprocal multiply, correct), sin scale, range multiply, output register.
// While the output is stalled the whole pipeline holds; one more beam is
// caught in a skid register, after which o_in_stall rises.
// Reset (synchronous, active low) empties the pipeline and clears both
// registers and the running angle to zero.
module lidar_polar_to_cartesian_core #(
    parameter int RANGE_BITS = 16,
    parameter int ANGLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config
    input  logic                            i_cfg_wen,
    input  logic [lp2c_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ANGLE_BITS-1:0]           i_cfg_wdata,
    // beam input
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [RANGE_BITS-1:0]           i_range_mm,
    input  logic                            i_range_valid,
    input  logic                            i_start_of_scan,
    // point output
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [RANGE_BITS:0]      o_x_mm,
    output logic signed [RANGE_BITS:0]      o_y_mm,
    output logic [ANGLE_BITS-1:0]           o_beam_angle
);
    import lp2c_pkg::*;

    localparam int FW   = ANGLE_BITS - 2;
    localparam int NSUB = 3 * HORNER_N;
    localparam int MW   = RANGE_BITS + QW;
    localparam logic [MW-1:0] HALF_LSB = MW'(1) << (QF - 1);

    // ------------------------------------------------------------------
    // config registers
    logic [ANGLE_BITS-1:0] r_angle_start;
    logic [ANGLE_BITS-1:0] r_angle_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_start <= '0;
            r_angle_step  <= '0;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                CFG_ANGLE_START: r_angle_start <= i_cfg_wdata;
                CFG_ANGLE_STEP:  r_angle_step  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline enable and input skid
    logic pipe_en;
    logic in_xfer;
    logic entry_fire;

    logic                  r_skid_valid;
    logic [RANGE_BITS-1:0] r_skid_range;
    logic                  r_skid_rvalid;
    logic                  r_skid_sos;

    logic                  r_out_valid;

    assign pipe_en    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_skid_valid;
    assign in_xfer    = i_in_valid && !r_skid_valid;
    assign entry_fire = pipe_en && (r_skid_valid || in_xfer);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (pipe_en) begin
            r_skid_valid <= 1'b0;
        end else if (in_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!pipe_en && in_xfer) begin
            r_skid_range  <= i_range_mm;
            r_skid_rvalid <= i_range_valid;
            r_skid_sos    <= i_start_of_scan;
        end
    end

    // ------------------------------------------------------------------
    // entry: beam angle
    logic [RANGE_BITS-1:0] ent_range;
    logic                  ent_rvalid;
    logic                  ent_sos;
    logic [ANGLE_BITS-1:0] ent_angle;
    logic [ANGLE_BITS-1:0] r_next_angle;

    assign ent_range  = r_skid_valid ? r_skid_range  : i_range_mm;
    assign ent_rvalid = r_skid_valid ? r_skid_rvalid : i_range_valid;
    assign ent_sos    = r_skid_valid ? r_skid_sos    : i_start_of_scan;
    assign ent_angle  = ent_sos ? r_angle_start : r_next_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_angle <= '0;
        end else if (entry_fire) begin
            r_next_angle <= ent_angle + r_angle_step;
        end
    end

    logic                  r_e_vld;
    logic [RANGE_BITS-1:0] r_e_rg;
    logic [ANGLE_BITS-1:0] r_e_an;

    // ------------------------------------------------------------------
    // theta = f * pi/2 in Q1.30
    logic [FW+QW-1:0]      th_prod;
    logic                  r_th_vld;
    logic [QW-1:0]         r_th_th;
    logic [RANGE_BITS-1:0] r_th_rg;
    logic [ANGLE_BITS-1:0] r_th_an;

    assign th_prod = r_e_an[FW-1:0] * HALF_PI_Q30;

    // ------------------------------------------------------------------
    // theta^2, then the Horner sideband line
    logic [2*QW-1:0]       x2_prod;
    logic                  r_sb_vld [NSUB+1];
    logic [XW-1:0]         r_sb_x2  [NSUB+1];
    logic [QW-1:0]         r_sb_th  [NSUB+1];
    logic [RANGE_BITS-1:0] r_sb_rg  [NSUB+1];
    logic [ANGLE_BITS-1:0] r_sb_an  [NSUB+1];

    assign x2_prod = r_th_th * r_th_th;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld  <= 1'b0;
            r_th_vld <= 1'b0;
            for (int k = 0; k <= NSUB; k++) begin
                r_sb_vld[k] <= 1'b0;
            end
        end else if (pipe_en) begin
            r_e_vld     <= entry_fire && ent_rvalid;
            r_th_vld    <= r_e_vld;
            r_sb_vld[0] <= r_th_vld;
            for (int k = 0; k < NSUB; k++) begin
                r_sb_vld[k+1] <= r_sb_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_e_rg     <= ent_range;
            r_e_an     <= ent_angle;
            r_th_th    <= th_prod[FW+QW-1:FW];
            r_th_rg    <= r_e_rg;
            r_th_an    <= r_e_an;
            r_sb_x2[0] <= x2_prod[QF+XW-1:QF];
            r_sb_th[0] <= r_th_th;
            r_sb_rg[0] <= r_th_rg;
            r_sb_an[0] <= r_th_an;
            for (int k = 0; k < NSUB; k++) begin
                r_sb_x2[k+1] <= r_sb_x2[k];
                r_sb_th[k+1] <= r_sb_th[k];
                r_sb_rg[k+1] <= r_sb_rg[k];
                r_sb_an[k+1] <= r_sb_an[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Horner steps: t = 1 - (x2 * t) / k, sin and cos side by side
    logic [XW-1:0] r_va_s [HORNER_N];
    logic [XW-1:0] r_va_c [HORNER_N];
    logic [XW-1:0] r_vb_s [HORNER_N];
    logic [XW-1:0] r_vb_c [HORNER_N];
    logic [XW-1:0] r_eb_s [HORNER_N];
    logic [XW-1:0] r_eb_c [HORNER_N];
    logic [QW-1:0] r_t_s  [HORNER_N];
    logic [QW-1:0] r_t_c  [HORNER_N];

    for (genvar j = 0; j < HORNER_N; j++) begin : g_step
        localparam logic [DIV_W-1:0] KS = SIN_DIV[j];
        localparam logic [DIV_W-1:0] KC = COS_DIV[j];
        // floor(2^32 / k): quotient estimate is at most one low
        localparam logic [XW-1:0] MS = XW'(RECIP_NUM / (XW+1)'(KS));
        localparam logic [XW-1:0] MC = XW'(RECIP_NUM / (XW+1)'(KC));

        logic [QW-1:0]    t_in_s;
        logic [QW-1:0]    t_in_c;
        logic [XW+QW-1:0] pa_s;
        logic [XW+QW-1:0] pa_c;
        logic [2*XW-1:0]  pb_s;
        logic [2*XW-1:0]  pb_c;

        if (j == 0) begin : g_first
            assign t_in_s = Q_ONE;
            assign t_in_c = Q_ONE;
        end else begin : g_next
            assign t_in_s = r_t_s[j-1];
            assign t_in_c = r_t_c[j-1];
        end

        // (x2 * t) >> 30 stays below 2^32 since t <= 1.0
        assign pa_s = r_sb_x2[3*j] * t_in_s;
        assign pa_c = r_sb_x2[3*j] * t_in_c;
        assign pb_s = r_va_s[j] * MS;
        assign pb_c = r_va_c[j] * MC;

        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r_va_s[j] <= pa_s[QF+XW-1:QF];
                r_va_c[j] <= pa_c[QF+XW-1:QF];
                r_vb_s[j] <= r_va_s[j];
                r_vb_c[j] <= r_va_c[j];
                r_eb_s[j] <= pb_s[2*XW-1:XW];
                r_eb_c[j] <= pb_c[2*XW-1:XW];
                r_t_s[j]  <= lp2c_horner_fix(r_vb_s[j], r_eb_s[j], KS);
                r_t_c[j]  <= lp2c_horner_fix(r_vb_c[j], r_eb_c[j], KC);
            end
        end
    end

    // ------------------------------------------------------------------
    // sin = theta * series, clamped to 1.0
    logic [2*QW-1:0]       s_prod;
    logic [XW-1:0]         s_raw;
    logic                  r_s_vld;
    logic [QW-1:0]         r_s_s;
    logic [QW-1:0]         r_s_c;
    logic [RANGE_BITS-1:0] r_s_rg;
    logic [ANGLE_BITS-1:0] r_s_an;

    assign s_prod = r_sb_th[NSUB] * r_t_s[HORNER_N-1];
    assign s_raw  = s_prod[QF+XW-1:QF];

    // ------------------------------------------------------------------
    // quadrant fold and range multiply with round to nearest
    logic [1:0]            quad;
    logic [QW-1:0]         cmag;
    logic [QW-1:0]         smag;
    logic                  cneg;
    logic                  sneg;
    logic [MW-1:0]         px_full;
    logic [MW-1:0]         py_full;
    logic                  r_m_vld;
    logic [RANGE_BITS-1:0] r_m_px;
    logic [RANGE_BITS-1:0] r_m_py;
    logic                  r_m_xneg;
    logic                  r_m_yneg;
    logic [RANGE_BITS-1:0] r_m_rg;
    logic [ANGLE_BITS-1:0] r_m_an;

    assign quad = r_s_an[ANGLE_BITS-1:ANGLE_BITS-2];

    always_comb begin
        cmag = r_s_c;
        cneg = 1'b0;
        smag = r_s_s;
        sneg = 1'b0;
        case (quad)
            QUAD_0: begin
                cmag = r_s_c;
                smag = r_s_s;
            end
            QUAD_1: begin
                cmag = r_s_s;
                cneg = 1'b1;
                smag = r_s_c;
            end
            QUAD_2: begin
                cneg = 1'b1;
                sneg = 1'b1;
            end
            QUAD_3: begin
                cmag = r_s_s;
                smag = r_s_c;
                sneg = 1'b1;
            end
            default: ;
        endcase
    end

    assign px_full = r_s_rg * cmag + HALF_LSB;
    assign py_full = r_s_rg * smag + HALF_LSB;

    // ------------------------------------------------------------------
    // output register
    logic signed [RANGE_BITS:0] r_out_x;
    logic signed [RANGE_BITS:0] r_out_y;
    logic [ANGLE_BITS-1:0]      r_out_an;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld     <= 1'b0;
            r_m_vld     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_s_vld     <= r_sb_vld[NSUB];
            r_m_vld     <= r_s_vld;
            r_out_valid <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s_s    <= (s_raw > XW'(Q_ONE)) ? Q_ONE : s_raw[QW-1:0];
            r_s_c    <= r_t_c[HORNER_N-1];
            r_s_rg   <= r_sb_rg[NSUB];
            r_s_an   <= r_sb_an[NSUB];
            r_m_px   <= px_full[QF+RANGE_BITS-1:QF];
            r_m_py   <= py_full[QF+RANGE_BITS-1:QF];
            r_m_xneg <= cneg;
            r_m_yneg <= sneg;
            r_m_rg   <= r_s_rg;
            r_m_an   <= r_s_an;
            r_out_x  <= r_m_xneg ? -$signed({1'b0, r_m_px}) : $signed({1'b0, r_m_px});
            r_out_y  <= r_m_yneg ? -$signed({1'b0, r_m_py}) : $signed({1'b0, r_m_py});
            r_out_an <= r_m_an;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_x_mm       = r_out_x;
    assign o_y_mm       = r_out_y;
    assign o_beam_angle = r_out_an;

    // ------------------------------------------------------------------
    // assertions
`include "lidar_polar_to_cartesian_core_assert.svh"

    `LP2C_ASSERT_NEXT(a_skid_catch, i_clk, i_rst_n, in_xfer && !pipe_en, r_skid_valid, "beam transferred while halted was not caught in skid")
    `LP2C_ASSERT_NOW(a_skid_only_when_halted, i_clk, i_rst_n, r_skid_valid, !$past(pipe_en), "skid holds a beam after the pipeline advanced")
    `LP2C_ASSERT_NOW(a_mag_le_range, i_clk, i_rst_n, r_m_vld, (r_m_px <= r_m_rg) && (r_m_py <= r_m_rg), "scaled magnitude exceeds range")

endmodule

// File: dv/lidar_polar_to_cartesian_core_test.sv
module lidar_polar_to_cartesian_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lp2c_pkg::*;

    localparam int RANGE_W = 16;
    localparam int ANGLE_W = 16;
    localparam longint unsigned UNIT_Q30 = 64'd1 << 30;
    localparam longint unsigned HALF_PI = 64'd1686629713;
    localparam int SETTLE_CYCLES = 40;     // pipeline is 30 stages deep
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int N_PHASES = 6;
    localparam int N_ROWS = 15;

    typedef struct packed {
        logic signed [RANGE_W:0] x;
        logic signed [RANGE_W:0] y;
        logic [ANGLE_W-1:0]      ang;
    } t_point;

    typedef struct packed {
        logic [RANGE_W-1:0] rng;
        logic               ok;
        logic               sos;
        logic               typed;   // expected point given in the row
        t_point             pt;
    } t_beam_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = CFG_ANGLE_START;
    logic [ANGLE_W-1:0]     i_cfg_wdata = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [RANGE_W-1:0]     i_range_mm = '0;
    logic                   i_range_valid = 1'b0;
    logic                   i_start_of_scan = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic signed [RANGE_W:0] o_x_mm;
    logic signed [RANGE_W:0] o_y_mm;
    logic [ANGLE_W-1:0]     o_beam_angle;

    // predictor state
    logic [ANGLE_W-1:0] cfg_start = '0;
    logic [ANGLE_W-1:0] cfg_step = '0;
    logic [ANGLE_W-1:0] run_angle = '0;
    t_point             point_q[$];

    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;
    int  fail_cnt = 0;
    int  quiet_cycles = 0;

    lidar_polar_to_cartesian_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_range_mm      (i_range_mm),
        .i_range_valid   (i_range_valid),
        .i_start_of_scan (i_start_of_scan),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_x_mm          (o_x_mm),
        .o_y_mm          (o_y_mm),
        .o_beam_angle    (o_beam_angle)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint unsigned series_div(input int i, input bit use_cos);
        case (i)
            0: return use_cos ? 240 : 272;
            1: return use_cos ? 182 : 210;
            2: return use_cos ? 132 : 156;
            3: return use_cos ? 90 : 110;
            4: return use_cos ? 56 : 72;
            5: return use_cos ? 30 : 42;
            6: return use_cos ? 12 : 20;
            default: return use_cos ? 2 : 6;
        endcase
    endfunction

    // Horner evaluation of the sin/cos series in Q1.30, clamped every stage
    function automatic longint unsigned taylor_q30(input longint unsigned x2,
                                                   input bit use_cos);
        longint unsigned t;
        longint unsigned sub;
        t = UNIT_Q30;
        for (int i = 0; i < 8; i++) begin
            sub = ((x2 * t) >> 30) / series_div(i, use_cos);
            t = (sub > UNIT_Q30) ? 64'd0 : UNIT_Q30 - sub;
        end
        return t;
    endfunction

    function automatic logic signed [RANGE_W:0] scale_range(input logic [RANGE_W-1:0] r,
                                                            input longint unsigned mag,
                                                            input bit neg);
        longint unsigned p;
        p = (longint'(r) * mag + (64'd1 << 29)) >> 30;
        if (neg) begin
            p = 64'd0 - p;
        end
        return p[RANGE_W:0];
    endfunction

    // Advances the running angle; returns 1 with the point for a valid beam.
    function automatic bit convert_beam(input logic [RANGE_W-1:0] rng, input bit ok,
                                        input bit sos, output t_point pt);
        logic [ANGLE_W-1:0] a;
        longint unsigned f;
        longint unsigned theta;
        longint unsigned x2;
        longint unsigned s;
        longint unsigned c;
        longint unsigned cmag;
        longint unsigned smag;
        bit cneg;
        bit sneg;
        a = sos ? cfg_start : run_angle;
        run_angle = a + cfg_step;
        pt = '0;
        if (!ok) begin
            return 1'b0;
        end
        f = a[ANGLE_W-3:0];
        theta = (f * HALF_PI) >> (ANGLE_W - 2);
        x2 = (theta * theta) >> 30;
        s = (theta * taylor_q30(x2, 1'b0)) >> 30;
        if (s > UNIT_Q30) begin
            s = UNIT_Q30;
        end
        c = taylor_q30(x2, 1'b1);
        case (a[ANGLE_W-1:ANGLE_W-2])
            QUAD_0: begin cmag = c; cneg = 0; smag = s; sneg = 0; end
            QUAD_1: begin cmag = s; cneg = 1; smag = c; sneg = 0; end
            QUAD_2: begin cmag = c; cneg = 1; smag = s; sneg = 1; end
            default: begin cmag = s; cneg = 0; smag = c; sneg = 1; end
        endcase
        pt.x = scale_range(rng, cmag, cneg);
        pt.y = scale_range(rng, smag, sneg);
        pt.ang = a;
        return 1'b1;
    endfunction

    // Receiver: random stalls, plus one long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Output checker; x/y may be off by 1 mm, angle must match exactly
    always @(posedge i_clk) begin
        t_point want;
        int dx;
        int dy;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (point_q.size() == 0) begin
                fail_cnt <= fail_cnt + 1;
                if (fail_cnt < 10) begin
                    $display("%0t: unexpected point x=%0d y=%0d angle=%h",
                             $realtime, o_x_mm, o_y_mm, o_beam_angle);
                end
            end else begin
                want = point_q.pop_front();
                dx = o_x_mm - want.x;
                dy = o_y_mm - want.y;
                if (dx > 1 || dx < -1 || dy > 1 || dy < -1 || o_beam_angle != want.ang) begin
                    fail_cnt <= fail_cnt + 1;
                    if (fail_cnt < 10) begin
                        $display("%0t: mismatch exp x=%0d y=%0d ang=%h got x=%0d y=%0d ang=%h",
                                 $realtime, want.x, want.y, want.ang,
                                 o_x_mm, o_y_mm, o_beam_angle);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin tx_idle_pct = 38; rx_idle_pct = 69; end
            1: begin tx_idle_pct = 69; rx_idle_pct = 38; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
        endcase
    endtask

    task automatic send_beam(input logic [RANGE_W-1:0] rng, input bit ok, input bit sos,
                             output bit has_pt, output t_point pt);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_range_mm <= rng;
        i_range_valid <= ok;
        i_start_of_scan <= sos;
        do @(posedge i_clk); while (o_in_stall);
        has_pt = convert_beam(rng, ok, sos, pt);
    endtask

    // Let every point out, then let beams without a point clear the pipe.
    task automatic drain_pipe();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (point_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [ANGLE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
        if (idx == CFG_ANGLE_START) begin
            cfg_start = val;
        end else begin
            cfg_step = val;
        end
    endtask

    function automatic logic [RANGE_W-1:0] pick_range();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return RANGE_W'($urandom_range(15));
            default: return RANGE_W'($urandom);
        endcase
    endfunction

    // First beam runs on the reset angle; step of a quarter turn walks the
    // quadrant boundaries, start is used from the first scan mark on.
    t_beam_row dir_rows[N_ROWS] = '{
        '{16'd65535, 1'b1, 1'b0, 1'b1, '{ 17'sd65535,  17'sd0,      16'h0000}},
        '{16'd65535, 1'b1, 1'b0, 1'b1, '{ 17'sd0,      17'sd65535,  16'h4000}},
        '{16'd65535, 1'b1, 1'b0, 1'b1, '{-17'sd65535,  17'sd0,      16'h8000}},
        '{16'd65535, 1'b1, 1'b0, 1'b1, '{ 17'sd0,     -17'sd65535,  16'hC000}},
        '{16'd0,     1'b1, 1'b0, 1'b1, '{ 17'sd0,      17'sd0,      16'h0000}},
        '{16'd65535, 1'b0, 1'b0, 1'b0, '0},
        '{16'd1,     1'b1, 1'b0, 1'b1, '{-17'sd1,      17'sd0,      16'h8000}},
        '{16'd1000,  1'b1, 1'b1, 1'b0, '0},
        '{16'd40000, 1'b0, 1'b1, 1'b0, '0},
        '{16'd54321, 1'b1, 1'b0, 1'b0, '0},
        '{16'd65535, 1'b1, 1'b1, 1'b0, '0},
        '{16'd12345, 1'b1, 1'b0, 1'b0, '0},
        '{16'd1,     1'b1, 1'b0, 1'b0, '0},
        '{16'd32768, 1'b1, 1'b0, 1'b0, '0},
        '{16'd0,     1'b0, 1'b0, 1'b0, '0}
    };

    initial begin
        bit has_pt;
        t_point pt;
        int sent;
        int scan_len;
        bit noisy;
        bit sos;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_cfg(CFG_ANGLE_START, 16'h1234);
        write_cfg(CFG_ANGLE_STEP, 16'h4000);
        set_idling(0);
        for (int i = 0; i < N_ROWS; i++) begin
            send_beam(dir_rows[i].rng, dir_rows[i].ok, dir_rows[i].sos, has_pt, pt);
            if (has_pt) begin
                point_q.insert(point_q.size(), dir_rows[i].typed ? dir_rows[i].pt : pt);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            drain_pipe();
            case (p)
                0: begin
                    write_cfg(CFG_ANGLE_START, 16'hFFFF);
                    write_cfg(CFG_ANGLE_STEP, 16'hFFFF);
                end
                1: begin
                    write_cfg(CFG_ANGLE_START, 16'h0000);
                    write_cfg(CFG_ANGLE_STEP, 16'h0000);
                end
                2: begin
                    write_cfg(CFG_ANGLE_START, ANGLE_W'($urandom));
                    write_cfg(CFG_ANGLE_STEP, 16'h0001);
                end
                default: begin
                    write_cfg(CFG_ANGLE_START, ANGLE_W'($urandom));
                    write_cfg(CFG_ANGLE_STEP, ANGLE_W'($urandom));
                end
            endcase
            set_idling(p / 2);
            if (p == 4) begin
                hold_req = 1'b1;    // long receiver hold-off to back up the pipe
            end
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                // mostly clean scans, some with stray or missing scan marks
                scan_len = $urandom_range(1, 40);
                noisy = ($urandom_range(9) == 0);
                for (int j = 0; j < scan_len && sent < ITEMS_PER_PHASE; j++) begin
                    if (noisy) begin
                        sos = ($urandom_range(7) == 0);
                    end else begin
                        sos = (j == 0);
                    end
                    send_beam(pick_range(), ($urandom_range(99) < 85), sos, has_pt, pt);
                    if (has_pt) begin
                        point_q.insert(point_q.size(), pt);
                    end
                    sent++;
                end
            end
        end

        drain_pipe();
        if (fail_cnt == 0 && point_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: lidar_polar_to_cartesian_core.f
+incdir+rtl
rtl/lp2c_pkg.sv
rtl/lidar_polar_to_cartesian_core.sv
dv/lidar_polar_to_cartesian_core_test.sv
